@@ src/fdt_pkg.sv @@
// types and constants shared by the fragment delivery tracker
package fdt_pkg;

  localparam int TAG_W         = 32;
  localparam int NUM_W         = 16;
  localparam int CNT_W         = 11;
  localparam int MAX_FRAGMENTS = 1024;
  localparam int IDX_W         = 10;
  localparam int EPOCH_W       = 8;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_RECORD = 2'd1,
    OP_FINAL  = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IN_PROGRESS = 4'd0,
    ST_COMPLETE    = 4'd1,
    ST_FAILED      = 4'd2,
    ST_STALE       = 4'd3,
    ST_WRONG_FRAME = 4'd4,
    ST_BAD_INDEX   = 4'd5,
    ST_DUPLICATE   = 4'd6,
    ST_BUSY        = 4'd7,
    ST_BAD_BEGIN   = 4'd8,
    ST_IDLE        = 4'd9
  } status_t;

endpackage

@@ src/fdt_in_if.sv @@
// input channel of the fragment delivery tracker
interface fdt_in_if;
  logic                       valid;
  logic                       ready;
  fdt_pkg::op_t               operation;
  logic [fdt_pkg::TAG_W-1:0]  frame_tag;
  logic                       key_frame;
  logic [fdt_pkg::NUM_W-1:0]  fragment_total;
  logic [fdt_pkg::NUM_W-1:0]  fragment_number;
  logic                       send_ok;

  modport source (
    output valid, operation, frame_tag, key_frame, fragment_total, fragment_number, send_ok,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_tag, key_frame, fragment_total, fragment_number, send_ok,
    output ready
  );
endinterface

@@ src/fdt_out_if.sv @@
// result channel of the fragment delivery tracker
interface fdt_out_if;
  logic                       valid;
  logic                       ready;
  fdt_pkg::status_t           status;
  logic                       is_active;
  logic                       is_terminal;
  logic [fdt_pkg::TAG_W-1:0]  report_tag;
  logic                       report_key;
  logic [fdt_pkg::CNT_W-1:0]  count_total;
  logic [fdt_pkg::CNT_W-1:0]  count_sent;
  logic                       send_error;

  modport source (
    output valid, status, is_active, is_terminal, report_tag, report_key,
           count_total, count_sent, send_error,
    input  ready
  );
  modport sink (
    input  valid, status, is_active, is_terminal, report_tag, report_key,
           count_total, count_sent, send_error,
    output ready
  );
endinterface

@@ src/fragment_delivery_tracker.sv @@
// fragment delivery tracker top level
//
// in_bus takes one word per cycle: begin, record fragment, finalize or reset.
// every accepted word yields exactly one word on out_bus, in order, carrying
// a status code and a snapshot of the delivery state after the word.
// each word is registered with its sent-bitmap read, then evaluated into the
// output register. throughput is one word per cycle when nothing stalls.
// the sent bitmap is a 1024-entry memory of epoch marks; an accepted begin
// or a reset bumps the epoch so the bitmap clears at once. after rst_n and
// after every 255th such bump, a clearing pass writes the whole memory, one
// entry a cycle; in_bus.ready is low during that pass.
// rst_n is synchronous: it clears all state and starts the clearing pass.
// when out_bus stalls, one more word is taken into the input register and
// then in_bus.ready drops until the output register is drained.
module fragment_delivery_tracker (
  input  logic         clk,
  input  logic         rst_n,
  fdt_in_if.sink       in_bus,
  fdt_out_if.source    out_bus
);

  localparam int TAG_W   = fdt_pkg::TAG_W;
  localparam int NUM_W   = fdt_pkg::NUM_W;
  localparam int CNT_W   = fdt_pkg::CNT_W;
  localparam int IDX_W   = fdt_pkg::IDX_W;
  localparam int EPOCH_W = fdt_pkg::EPOCH_W;
  localparam int DEPTH   = fdt_pkg::MAX_FRAGMENTS;
  localparam logic [NUM_W-1:0] MAX_NUM  = NUM_W'(fdt_pkg::MAX_FRAGMENTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // epoch memory
  logic [EPOCH_W-1:0] map_mem [DEPTH];

  // input stage
  logic                s1_v_r;
  fdt_pkg::op_t        s1_op_r;
  logic [TAG_W-1:0]    s1_tag_r;
  logic                s1_key_r;
  logic [NUM_W-1:0]    s1_total_r;
  logic [NUM_W-1:0]    s1_idx_r;
  logic                s1_ok_r;
  logic [EPOCH_W-1:0]  s1_rd_r;
  logic                s1_fwd_r;
  logic                s1_clr_r;

  // tracker state
  logic                open_r, open_nxt;
  logic                final_r, final_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic                key_r, key_nxt;
  logic                err_r, err_nxt;
  logic [CNT_W-1:0]    expected_r, expected_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;

  // clearing pass
  logic                clr_busy_r;
  logic [IDX_W-1:0]    clr_idx_r;

  // output register
  logic                out_v_r;
  fdt_pkg::status_t    out_status_r;
  logic                out_active_r;
  logic                out_terminal_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic                out_key_r;
  logic [CNT_W-1:0]    out_total_r;
  logic [CNT_W-1:0]    out_sent_r;
  logic                out_err_r;

  logic                in_fire;
  logic                s2_fire;
  logic                sent_bit;
  logic                wr_en;
  logic                bump;
  logic                clr_start;
  logic                stale_fin;
  logic [IDX_W-1:0]    wr_addr;
  fdt_pkg::status_t    st;

  assign s2_fire      = s1_v_r && !clr_busy_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !clr_busy_r && (!s1_v_r || s2_fire);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign wr_addr      = s1_idx_r[IDX_W-1:0];

  // bit is set if the previous word just wrote it, or its mark matches the epoch
  assign sent_bit = s1_fwd_r || (!s1_clr_r && (s1_rd_r == epoch_r));

  always_comb begin
    open_nxt     = open_r;
    final_nxt    = final_r;
    tag_nxt      = tag_r;
    key_nxt      = key_r;
    err_nxt      = err_r;
    expected_nxt = expected_r;
    done_nxt     = done_r;
    wr_en        = 1'b0;
    bump         = 1'b0;
    stale_fin    = 1'b0;
    st           = fdt_pkg::ST_IN_PROGRESS;
    case (s1_op_r)
      fdt_pkg::OP_BEGIN: begin
        if (open_r && !final_r) begin
          st = fdt_pkg::ST_BUSY;
        end else if (s1_tag_r == '0 || s1_total_r == '0 || s1_total_r > MAX_NUM) begin
          st = fdt_pkg::ST_BAD_BEGIN;
        end else begin
          open_nxt     = 1'b1;
          final_nxt    = 1'b0;
          tag_nxt      = s1_tag_r;
          key_nxt      = s1_key_r;
          err_nxt      = 1'b0;
          expected_nxt = s1_total_r[CNT_W-1:0];
          done_nxt     = '0;
          bump         = 1'b1;
          st           = fdt_pkg::ST_IN_PROGRESS;
        end
      end
      fdt_pkg::OP_RECORD: begin
        if (!open_r || final_r) begin
          st = fdt_pkg::ST_STALE;
        end else if (s1_tag_r != tag_r) begin
          st = fdt_pkg::ST_WRONG_FRAME;
        end else if (err_r) begin
          st = fdt_pkg::ST_FAILED;
        end else if (s1_idx_r >= {{(NUM_W-CNT_W){1'b0}}, expected_r}) begin
          st = fdt_pkg::ST_BAD_INDEX;
        end else if (!s1_ok_r) begin
          err_nxt = 1'b1;
          st      = fdt_pkg::ST_FAILED;
        end else if (sent_bit) begin
          st = fdt_pkg::ST_DUPLICATE;
        end else begin
          wr_en    = 1'b1;
          done_nxt = done_r + CNT_W'(1);
          st       = (done_nxt == expected_r) ? fdt_pkg::ST_COMPLETE
                                              : fdt_pkg::ST_IN_PROGRESS;
        end
      end
      fdt_pkg::OP_FINAL: begin
        if (!open_r || final_r) begin
          stale_fin = 1'b1;
          st        = fdt_pkg::ST_STALE;
        end else if (s1_tag_r != tag_r) begin
          st = fdt_pkg::ST_WRONG_FRAME;
        end else begin
          final_nxt = 1'b1;
          st        = (!err_r && done_r == expected_r) ? fdt_pkg::ST_COMPLETE
                                                       : fdt_pkg::ST_FAILED;
        end
      end
      fdt_pkg::OP_RESET: begin
        open_nxt     = 1'b0;
        final_nxt    = 1'b0;
        tag_nxt      = '0;
        key_nxt      = 1'b0;
        err_nxt      = 1'b0;
        expected_nxt = '0;
        done_nxt     = '0;
        bump         = 1'b1;
        st           = fdt_pkg::ST_IDLE;
      end
      default: begin
        st = fdt_pkg::ST_IDLE;
      end
    endcase
  end

  // epoch bump, with a clearing pass when the mark wraps
  always_comb begin
    epoch_nxt = epoch_r;
    clr_start = 1'b0;
    if (bump) begin
      if (epoch_r == '1) begin
        epoch_nxt = EPOCH_W'(1);
        clr_start = 1'b1;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      map_mem[clr_idx_r] <= '0;
    end else if (s2_fire && wr_en) begin
      map_mem[wr_addr] <= epoch_r;
    end
    if (in_fire) begin
      s1_rd_r <= map_mem[in_bus.fragment_number[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_bus.operation;
      s1_tag_r   <= in_bus.frame_tag;
      s1_key_r   <= in_bus.key_frame;
      s1_total_r <= in_bus.fragment_total;
      s1_idx_r   <= in_bus.fragment_number;
      s1_ok_r    <= in_bus.send_ok;
      s1_fwd_r   <= s2_fire && wr_en && (wr_addr == in_bus.fragment_number[IDX_W-1:0]);
      s1_clr_r   <= s2_fire && bump;
    end
    if (s2_fire) begin
      out_status_r   <= st;
      out_active_r   <= open_nxt;
      out_terminal_r <= stale_fin ? 1'b1 : final_nxt;
      out_tag_r      <= stale_fin ? s1_tag_r : tag_nxt;
      out_key_r      <= stale_fin ? 1'b0 : key_nxt;
      out_total_r    <= stale_fin ? '0 : expected_nxt;
      out_sent_r     <= stale_fin ? '0 : done_nxt;
      out_err_r      <= stale_fin ? 1'b0 : err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      open_r     <= 1'b0;
      final_r    <= 1'b0;
      tag_r      <= '0;
      key_r      <= 1'b0;
      err_r      <= 1'b0;
      expected_r <= '0;
      done_r     <= '0;
      epoch_r    <= EPOCH_W'(1);
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s2_fire) begin
        s1_v_r <= 1'b0;
      end
      out_v_r <= s2_fire || (out_v_r && !out_bus.ready);
      if (s2_fire) begin
        open_r     <= open_nxt;
        final_r    <= final_nxt;
        tag_r      <= tag_nxt;
        key_r      <= key_nxt;
        err_r      <= err_nxt;
        expected_r <= expected_nxt;
        done_r     <= done_nxt;
        epoch_r    <= epoch_nxt;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          clr_busy_r <= 1'b0;
        end
      end else if (s2_fire && clr_start) begin
        clr_busy_r <= 1'b1;
        clr_idx_r  <= '0;
      end
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.status      = out_status_r;
  assign out_bus.is_active   = out_active_r;
  assign out_bus.is_terminal = out_terminal_r;
  assign out_bus.report_tag  = out_tag_r;
  assign out_bus.report_key  = out_key_r;
  assign out_bus.count_total = out_total_r;
  assign out_bus.count_sent  = out_sent_r;
  assign out_bus.send_error  = out_err_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_fire)
    else $error("word accepted during clearing pass");

  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= expected_r)
    else $error("sent count above fragment total");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch mark reached zero");

  a_complete_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r == fdt_pkg::ST_COMPLETE) |-> (out_sent_r == out_total_r))
    else $error("complete reported with fragments missing");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_bus.ready) |=> (out_v_r && $stable(out_status_r)))
    else $error("stalled result changed");
`endif

endmodule
